// ----- src/ccl_pkg.sv -----
// ----------------------------------------------------------------------------
// ccl_pkg
// Shared types and constants of the connected component labeler.
// ----------------------------------------------------------------------------
package ccl_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 128;
  localparam int unsigned PixCap    = MaxWidth * MaxHeight;

  localparam int unsigned ColW  = $clog2(MaxWidth);
  localparam int unsigned RowW  = $clog2(MaxHeight);
  localparam int unsigned PixW  = $clog2(PixCap);
  localparam int unsigned LblW  = 16;
  localparam int unsigned WCfgW = 9;
  localparam int unsigned HCfgW = 8;
  localparam int unsigned CfgW  = 9;

  // parent table holds labels 0..PixCap
  localparam int unsigned ParDepth = PixCap + 1;
  localparam int unsigned ParAw    = $clog2(ParDepth);

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef struct packed {
    logic       opcode;
    logic [7:0] pixel_value;
  } cmd_t;

  typedef struct packed {
    logic [LblW-1:0] label;
    logic            last_label;
  } result_t;

  typedef enum logic [1:0] {
    JOB_INIT  = 2'd0,
    JOB_UNION = 2'd1,
    JOB_FIND  = 2'd2
  } job_op_e;

  typedef struct packed {
    job_op_e         op;
    logic [LblW-1:0] a;
    logic [LblW-1:0] b;
    logic            last;
  } job_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_LOAD,
    FR_READ
  } front_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FP,
    BK_FG
  } back_state_e;

endpackage

// ----- src/ccl_job_fifo.sv -----
// ----------------------------------------------------------------------------
// ccl_job_fifo
// Small job queue between the pixel front end and the union-find engine.
// ----------------------------------------------------------------------------
module ccl_job_fifo
  import ccl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t pop_job_o
);

  job_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o    = (cnt_q == FifoCntW'(FifoDepth));
  assign valid_o   = (cnt_q != '0);
  assign pop_job_o = mem_q[rd_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  // pointer and count update
  always_comb begin
    wr_d  = do_push ? wr_q + FifoPtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + FifoPtrW'(1) : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + FifoCntW'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - FifoCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_job_i;
  end

endmodule

// ----- src/ccl_front.sv -----
// ----------------------------------------------------------------------------
// ccl_front
// Accepts commands, assigns provisional labels and queues union-find jobs.
// ----------------------------------------------------------------------------
module ccl_front
  import ccl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  cmd_t             cmd_i,
  output logic             busy_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CfgW-1:0]  cfg_data_i,
  input  logic             fifo_full_i,
  output logic             push_o,
  output job_t             push_job_o
);

  front_state_e state_q, state_d;

  logic [WCfgW-1:0] weff_q;
  logic [HCfgW-1:0] heff_q;
  logic [PixW:0]    total;

  logic [ColW-1:0] col_q;
  logic [RowW-1:0] row_q;
  logic [PixW-1:0] pix_q;
  logic [LblW-1:0] next_q;
  logic [PixW-1:0] ridx_q;
  logic            complete_q;
  logic [7:0]      left_pix_q;
  logic [LblW-1:0] left_lab_q;
  logic [7:0]      v_q;
  logic            last_q;

  // memories: provisional labels and the row above {pixel, label}
  logic [LblW-1:0]  label_mem [PixCap];
  logic [7+LblW:0]  row_mem   [MaxWidth];
  logic [LblW-1:0]  lab_rd_q;
  logic [7+LblW:0]  row_rd_q;

  logic accept, do_load, do_read, rd_last;
  logic left_ok, top_ok;
  logic [7:0]      top_pix;
  logic [LblW-1:0] top_lab, lab;
  logic            new_lab;
  logic            col_end, row_end;

  assign total   = (PixW+1)'(weff_q) * (PixW+1)'(heff_q);
  assign busy_o  = (state_q != FR_IDLE) || fifo_full_i;
  assign accept  = start_i && !busy_o;
  assign do_load = accept && (cmd_i.opcode == OP_LOAD) && !complete_q;
  assign do_read = accept && (cmd_i.opcode == OP_READ) && complete_q &&
                   ({1'b0, ridx_q} < total);
  assign rd_last = ({1'b0, ridx_q} == total - (PixW+1)'(1));

  assign top_pix = row_rd_q[7+LblW:LblW];
  assign top_lab = row_rd_q[LblW-1:0];
  assign col_end = ({1'b0, col_q} == weff_q - WCfgW'(1));
  assign row_end = ({1'b0, row_q} == heff_q - HCfgW'(1));

  // label choice for the pixel in flight
  always_comb begin
    left_ok = (col_q != '0) && (v_q == left_pix_q);
    top_ok  = (row_q != '0) && (v_q == top_pix);
    new_lab = 1'b0;
    push_o  = 1'b0;
    push_job_o = '{op: JOB_INIT, a: '0, b: '0, last: 1'b0};
    if (left_ok && top_ok) begin
      lab = (left_lab_q < top_lab) ? left_lab_q : top_lab;
      if (left_lab_q != top_lab) begin
        push_o = (state_q == FR_LOAD);
        push_job_o = '{op: JOB_UNION, a: left_lab_q, b: top_lab, last: 1'b0};
      end
    end else if (left_ok) begin
      lab = left_lab_q;
    end else if (top_ok) begin
      lab = top_lab;
    end else begin
      lab     = next_q + LblW'(1);
      new_lab = 1'b1;
      push_o  = (state_q == FR_LOAD);
      push_job_o = '{op: JOB_INIT, a: lab, b: '0, last: 1'b0};
    end
    if (state_q == FR_READ) begin
      push_o = 1'b1;
      push_job_o = '{op: JOB_FIND, a: lab_rd_q, b: '0, last: last_q};
    end
  end

  // state machine
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FR_IDLE: begin
        if (do_load) state_d = FR_LOAD;
        else if (do_read) state_d = FR_READ;
      end
      FR_LOAD: state_d = FR_IDLE;
      FR_READ: state_d = FR_IDLE;
      default: state_d = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FR_IDLE;
      weff_q     <= WCfgW'(MaxWidth);
      heff_q     <= HCfgW'(MaxHeight);
      col_q      <= '0;
      row_q      <= '0;
      pix_q      <= '0;
      next_q     <= '0;
      ridx_q     <= '0;
      complete_q <= 1'b0;
      left_pix_q <= '0;
      left_lab_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        // any size write starts a fresh image
        if (cfg_idx_i == CFG_WIDTH) begin
          if (cfg_data_i == '0) weff_q <= WCfgW'(1);
          else if (cfg_data_i > CfgW'(MaxWidth)) weff_q <= WCfgW'(MaxWidth);
          else weff_q <= cfg_data_i;
        end else begin
          if (cfg_data_i[HCfgW-1:0] == '0) heff_q <= HCfgW'(1);
          else if (cfg_data_i[HCfgW-1:0] > HCfgW'(MaxHeight)) heff_q <= HCfgW'(MaxHeight);
          else heff_q <= cfg_data_i[HCfgW-1:0];
        end
        col_q      <= '0;
        row_q      <= '0;
        pix_q      <= '0;
        next_q     <= '0;
        ridx_q     <= '0;
        complete_q <= 1'b0;
        left_pix_q <= '0;
      end else if (do_read) begin
        if (rd_last) begin
          col_q      <= '0;
          row_q      <= '0;
          pix_q      <= '0;
          next_q     <= '0;
          ridx_q     <= '0;
          complete_q <= 1'b0;
          left_pix_q <= '0;
        end else begin
          ridx_q <= ridx_q + PixW'(1);
        end
      end else if (state_q == FR_LOAD) begin
        left_pix_q <= v_q;
        left_lab_q <= lab;
        if (new_lab) next_q <= lab;
        pix_q <= pix_q + PixW'(1);
        if (col_end) begin
          col_q <= '0;
          row_q <= row_q + RowW'(1);
          if (row_end) begin
            complete_q <= 1'b1;
            ridx_q     <= '0;
          end
        end else begin
          col_q <= col_q + ColW'(1);
        end
      end
    end
  end

  // payload registers and memories
  always_ff @(posedge clk_i) begin
    if (do_load) v_q <= cmd_i.pixel_value;
    if (do_read) last_q <= rd_last;
    row_rd_q <= row_mem[col_q];
    lab_rd_q <= label_mem[ridx_q];
    if (state_q == FR_LOAD) begin
      label_mem[pix_q] <= lab;
      row_mem[col_q]   <= {v_q, lab};
    end
  end

endmodule

// ----- src/ccl_back.sv -----
// ----------------------------------------------------------------------------
// ccl_back
// Union-find engine on the parent table, find with path halving.
// ----------------------------------------------------------------------------
module ccl_back
  import ccl_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    job_valid_i,
  input  job_t    job_i,
  output logic    pop_o,
  output logic    result_valid_o,
  output result_t result_o
);

  back_state_e state_q, state_d;

  logic [LblW-1:0] par_mem [ParDepth];
  logic [LblW-1:0] rd_q;
  logic [ParAw-1:0] rd_addr;
  logic             we;
  logic [ParAw-1:0] wa;
  logic [LblW-1:0]  wd;

  job_op_e         op_q, op_d;
  logic [LblW-1:0] b_q, b_d;
  logic            last_q, last_d;
  logic            phase_q, phase_d;
  logic [LblW-1:0] x_q, x_d;
  logic [LblW-1:0] ra_q, ra_d;
  logic            res_v_q, res_v_d;
  result_t         res_q, res_d;

  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

  // find walk: root test on parent[x], halving write of grandparent
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    b_d     = b_q;
    last_d  = last_q;
    phase_d = phase_q;
    x_d     = x_q;
    ra_d    = ra_q;
    res_v_d = 1'b0;
    res_d   = res_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    wa      = x_q;
    wd      = rd_q;
    rd_addr = x_q;
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          pop_o = 1'b1;
          if (job_i.op == JOB_INIT) begin
            we = 1'b1;
            wa = job_i.a;
            wd = job_i.a;
          end else begin
            op_d    = job_i.op;
            b_d     = job_i.b;
            last_d  = job_i.last;
            phase_d = 1'b0;
            x_d     = job_i.a;
            rd_addr = job_i.a;
            state_d = BK_FP;
          end
        end
      end
      BK_FP: begin
        if (rd_q == x_q) begin
          if (op_q == JOB_FIND) begin
            res_v_d = 1'b1;
            res_d   = '{label: x_q, last_label: last_q};
            state_d = BK_IDLE;
          end else if (!phase_q) begin
            ra_d    = x_q;
            x_d     = b_q;
            rd_addr = b_q;
            phase_d = 1'b1;
          end else begin
            we      = 1'b1;
            wa      = ra_q;
            wd      = x_q;
            state_d = BK_IDLE;
          end
        end else begin
          rd_addr = rd_q;
          state_d = BK_FG;
        end
      end
      BK_FG: begin
        we      = 1'b1;
        wa      = x_q;
        wd      = rd_q;
        x_d     = rd_q;
        rd_addr = rd_q;
        state_d = BK_FP;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      res_v_q <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    b_q     <= b_d;
    last_q  <= last_d;
    phase_q <= phase_d;
    x_q     <= x_d;
    ra_q    <= ra_d;
    res_q   <= res_d;
    rd_q    <= par_mem[rd_addr];
    if (we) par_mem[wa] <= wd;
  end

endmodule

// ----- src/connected_component_labeler_unit.sv -----
// ----------------------------------------------------------------------------
// connected_component_labeler_unit
// 4-connected component labeler: load pixels in raster order, read roots.
// ----------------------------------------------------------------------------
// Load: the front end labels each pixel; a merge or new label queues a
//   job for the union-find engine, which walks the parent table hop by hop.
// Readout: a find job per pixel walks the parent table to the root label.
// busy_o rises while the front end works or the job queue is full.
// Reset: counters cleared, size 256 x 128; parent entries are written when a
//   label is created, so no clearing pass is needed. Results cannot stall.
module connected_component_labeler_unit
  import ccl_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  cmd_t            cmd_i,
  output logic            busy_o,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i,
  output logic            result_valid_o,
  output result_t         result_o
);

  logic fifo_full, push, pop, job_valid;
  job_t push_job, pop_job;

  ccl_front u_front (
    .clk_i, .rst_ni, .start_i, .cmd_i, .busy_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .push_job_o  (push_job)
  );

  ccl_job_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .valid_o    (job_valid),
    .pop_job_o  (pop_job)
  );

  ccl_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i (job_valid),
    .job_i       (pop_job),
    .pop_o       (pop),
    .result_valid_o,
    .result_o
  );

endmodule

// ----- src/ccl_checker.sv -----
// ----------------------------------------------------------------------------
// ccl_checker
// Port-level checks of the labeler, bound to the top level.
// ----------------------------------------------------------------------------
module ccl_checker
  import ccl_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    result_valid_o,
  input result_t result_o
);

  // labels are never zero
  a_label_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.label != '0))
    else $error("zero label");

  // labels stay within the parent table
  a_label_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.label <= LblW'(PixCap)))
    else $error("label out of range");

  // a find result is never followed directly by another result
  a_no_b2b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back to back results");

endmodule

bind connected_component_labeler_unit ccl_checker u_ccl_checker (
  .clk_i, .rst_ni, .result_valid_o, .result_o
);

// ----- bench/connected_component_labeler_unit_tb.sv -----
// ----------------------------------------------------------------------------
// connected_component_labeler_unit_tb
// Self-checking bench for the 4-connected component labeler. Images are
// loaded pixel by pixel and their root labels are read back. A behavioral
// union-find labeler in the bench predicts every readout, and the bench
// compares each result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module connected_component_labeler_unit_tb;
  import ccl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DrainCycles = 1000;
  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned RandItems   = 1200;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start_i = 1'b0;
  cmd_t            cmd_i = '0;
  logic            busy_o;
  logic            cfg_we_i = 1'b0;
  logic            cfg_idx_i = 1'b0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic            result_valid_o;
  result_t         result_o;

  connected_component_labeler_unit dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioral labeler
  // --------------------------------------------------------------------------
  logic [LblW-1:0] lbl_mem [PixCap];
  logic [7:0]      row_above [MaxWidth];
  int unsigned     parent [ParDepth];
  int unsigned     col_cnt, row_cnt, lbl_next, rd_idx;
  logic [7:0]      left_px;
  bit              img_done;
  logic [WCfgW-1:0] width_reg;
  logic [HCfgW-1:0] height_reg;

  function automatic void image_restart();
    for (int i = 0; i < ParDepth; i++) parent[i] = i;
    col_cnt = 0; row_cnt = 0; lbl_next = 0; rd_idx = 0;
    left_px = '0; img_done = 1'b0;
  endfunction

  function automatic int unsigned root_find(int unsigned x);
    if (x > PixCap) x = PixCap;
    while (parent[x] != x) begin
      parent[x] = parent[parent[x]];  // path halving
      x = parent[x];
    end
    return x;
  endfunction

  function automatic int unsigned eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > MaxWidth) return MaxWidth;
    return width_reg;
  endfunction

  function automatic int unsigned eff_h();
    if (height_reg == 0) return 1;
    if (height_reg > MaxHeight) return MaxHeight;
    return height_reg;
  endfunction

  function automatic void size_write(cfg_idx_e idx, logic [CfgW-1:0] d);
    if (idx == CFG_WIDTH) width_reg = d[WCfgW-1:0];
    else height_reg = d[HCfgW-1:0];
    image_restart();
  endfunction

  // returns 1 when the command produces a readout
  function automatic bit label_step(cmd_t c, output result_t r);
    int unsigned w, h, p, lab, ll, tl, ra, rb;
    bit lok, tok;
    w = eff_w(); h = eff_h();
    r = '0;
    if (c.opcode == OP_LOAD) begin
      if (img_done || col_cnt >= w || row_cnt >= h) return 1'b0;
      p = row_cnt * w + col_cnt;
      lok = (col_cnt > 0) && (c.pixel_value == left_px);
      tok = (row_cnt > 0) && (c.pixel_value == row_above[col_cnt]);
      ll = lok ? lbl_mem[p-1] : 0;
      tl = tok ? lbl_mem[p-w] : 0;
      if (lok && tok) begin
        lab = (ll < tl) ? ll : tl;
        if (ll != tl) begin
          ra = root_find(ll);
          rb = root_find(tl);
          parent[root_find(ra)] = root_find(rb);
        end
      end else if (lok) lab = ll;
      else if (tok) lab = tl;
      else begin
        lbl_next++;
        lab = lbl_next;
      end
      lbl_mem[p] = lab;
      row_above[col_cnt] = c.pixel_value;
      left_px = c.pixel_value;
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
      end
      if (row_cnt >= h) begin
        img_done = 1'b1;
        rd_idx = 0;
      end
      return 1'b0;
    end
    if (!img_done || rd_idx >= w * h) return 1'b0;
    r.label = LblW'(root_find(lbl_mem[rd_idx]));
    r.last_label = (rd_idx + 1 == w * h);
    rd_idx++;
    if (r.last_label) image_restart();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  result_t     pending_labels [$];
  int unsigned errors, stall_cnt, n_cmds, n_results, n_images, n_cfg;

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && result_valid_o) begin
      n_results++;
      if (pending_labels.size() == 0) begin
        $error("unexpected result transaction: label %0d last %0b",
               result_o.label, result_o.last_label);
        errors++;
      end else begin
        e = pending_labels.pop_front();
        if (result_o.label !== e.label) begin
          $error("label: expected %0d, got %0d", e.label, result_o.label);
          errors++;
        end
        if (result_o.last_label !== e.last_label) begin
          $error("last_label: expected %0b, got %0b", e.last_label, result_o.last_label);
          errors++;
        end
        if (e.last_label) n_images++;
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || result_valid_o || (start_i && !busy_o) || cfg_we_i) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers (entered right after a rising edge)
  // --------------------------------------------------------------------------
  bit no_idle;

  // typed: use exp instead of the prediction
  task automatic send_cmd(cmd_t c, bit typed = 1'b0, result_t exp = '0);
    result_t r;
    start_i <= 1'b1;
    cmd_i   <= c;
    do @(posedge clk_i); while (busy_o);
    n_cmds++;
    if (label_step(c, r)) pending_labels.insert(pending_labels.size(), typed ? exp : r);
    // long stretch with no gaps between commands
    no_idle = (n_cmds > 300 && n_cmds < 600);
    if (!no_idle && $urandom_range(99) < 23) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_labels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CfgW-1:0] d);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    size_write(idx, d);
    n_cfg++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  typedef struct {
    bit              is_cfg;
    cfg_idx_e        idx;
    logic [CfgW-1:0] data;
    cmd_t            cmd;
    bit              typed;
    result_t         exp;
  } dir_row_t;

  dir_row_t dir_tab [$];

  function automatic void add_row(dir_row_t r);
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  function automatic dir_row_t cfg_row(cfg_idx_e i, int d);
    return '{1'b1, i, CfgW'(d), '0, 1'b0, '0};
  endfunction

  function automatic dir_row_t ld_row(int v);
    return '{1'b0, CFG_WIDTH, '0, '{OP_LOAD, 8'(v)}, 1'b0, '0};
  endfunction

  function automatic dir_row_t rd_row(bit typed = 0, int lbl = 0, bit last = 0);
    return '{1'b0, CFG_WIDTH, '0, '{OP_READ, 8'h00}, typed, '{LblW'(lbl), last}};
  endfunction

  // one random image; noise and aborts mixed in
  task automatic random_image(int unsigned w, int unsigned h, bit wide_px);
    int unsigned total, cut;
    cmd_t c;
    total = w * h;
    cut = ($urandom_range(99) < 10) ? $urandom_range(total) : total + 1;
    for (int unsigned i = 0; i < total; i++) begin
      if (i == cut) return;  // abort: next size write restarts the image
      if ($urandom_range(99) < 8) send_cmd('{OP_READ, 8'($urandom)});
      c.opcode = OP_LOAD;
      c.pixel_value = wide_px ? 8'($urandom) : 8'($urandom_range(2));
      send_cmd(c);
    end
    for (int unsigned i = 0; i < total; i++) begin
      if ($urandom_range(99) < 8) send_cmd('{OP_LOAD, 8'($urandom)});
      send_cmd('{OP_READ, 8'($urandom)});
    end
  endtask

  initial begin
    int unsigned w, h;
    logic [CfgW-1:0] wd, hd;
    bit wide;
    width_reg = 9'd256; height_reg = 8'd128;
    image_restart();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // two pixels, distinct values; ignored load in readout
    add_row(cfg_row(CFG_WIDTH, 2));
    add_row(cfg_row(CFG_HEIGHT, 1));
    add_row(rd_row());
    add_row(ld_row(0));
    add_row(ld_row(255));
    add_row(rd_row(1, 1, 0));
    add_row(ld_row(0));
    add_row(rd_row(1, 2, 1));
    // merge of two labels, ignored readout while loading
    add_row(cfg_row(CFG_WIDTH, 3));
    add_row(cfg_row(CFG_HEIGHT, 2));
    add_row(ld_row(7));
    add_row(ld_row(8));
    add_row(ld_row(7));
    add_row(rd_row());
    add_row(ld_row(7));
    add_row(ld_row(7));
    add_row(ld_row(7));
    // label 1 is linked under label 3
    add_row(rd_row(1, 3, 0));
    add_row(rd_row(1, 2, 0));
    add_row(rd_row(1, 3, 0));
    add_row(rd_row());
    add_row(rd_row());
    add_row(rd_row(1, 3, 1));
    // zero sizes act as one
    add_row(cfg_row(CFG_WIDTH, 0));
    add_row(cfg_row(CFG_HEIGHT, 0));
    add_row(ld_row(8'h5a));
    add_row(rd_row(1, 1, 1));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) cfg_write(dir_tab[i].idx, dir_tab[i].data);
      else send_cmd(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].exp);
    end

    // oversize extremes, then random small images
    cfg_write(CFG_WIDTH, 9'h1ff);
    cfg_write(CFG_HEIGHT, 1);
    random_image(MaxWidth, 1, 1'b0);
    cfg_write(CFG_WIDTH, 1);
    cfg_write(CFG_HEIGHT, 9'h0ff);
    random_image(1, MaxHeight, 1'b1);

    while (n_cmds < RandItems + dir_tab.size()) begin
      if ($urandom_range(99) < 5) begin
        wd = CfgW'($urandom_range(511));
        hd = CfgW'($urandom_range(2));
      end else begin
        wd = CfgW'($urandom_range(1, 12));
        hd = CfgW'($urandom_range(1, 8));
      end
      hd[8] = $urandom_range(1);  // ignored bit of the height register
      if ($urandom_range(1)) begin
        cfg_write(CFG_WIDTH, wd);
        cfg_write(CFG_HEIGHT, hd);
      end else begin
        cfg_write(CFG_HEIGHT, hd);
        cfg_write(CFG_WIDTH, wd);
      end
      w = eff_w(); h = eff_h();
      wide = ($urandom_range(99) < 25);
      random_image(w, h, wide);
    end

    drain();
    $display("ran %0d commands, %0d size writes, %0d results over %0d images",
             n_cmds, n_cfg, n_results, n_images);
    $display("covered merges, ignored commands, aborts and clamped sizes");
    if (errors == 0 && pending_labels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
